### design/color_matrix_fit_and_apply_core_assert.svh
// Assertion macros used by the checker of the colour matrix core.
// CMFA_ASSERT_RST: a clocked assertion that is held off while reset is low.
// CMFA_ASSERT_ALWAYS: a clocked assertion that also holds through reset.
`ifndef COLOR_MATRIX_FIT_AND_APPLY_CORE_ASSERT_SVH
`define COLOR_MATRIX_FIT_AND_APPLY_CORE_ASSERT_SVH

`define CMFA_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CMFA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cmfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfa_pkg: shared types and constants
// Widths of the fit sums, the solver datapath and the queued word format.
// ----------------------------------------------------------------------------
package cmfa_pkg;

    localparam int MAX_PAIRS      = 64;
    localparam int COEF_FRAC_BITS = 12;
    localparam int CNT_W          = 7;
    localparam int SUM_W          = 22;
    localparam int PROD_W         = 2 * SUM_W;
    localparam int ADJ_W          = PROD_W + 1;
    localparam int LO_W           = SUM_W + 1;
    localparam int HI_W           = ADJ_W - LO_W;
    localparam int ACC_W          = ADJ_W + SUM_W + 3;
    localparam int Q_W            = 17;
    localparam int DIV_W          = ACC_W + COEF_FRAC_BITS + Q_W + 3;
    localparam int COEF_W         = 16;
    localparam int PIX_W          = COEF_W + 11;

    // fit status codes
    localparam logic [1:0] FIT_OK       = 2'd0;
    localparam logic [1:0] FIT_SINGULAR = 2'd1;
    localparam logic [1:0] FIT_SAT      = 2'd2;

    typedef enum logic [1:0] {
        K_PIXEL,
        K_PAIR,
        K_SOLVE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] t_blue;
        logic [7:0] t_green;
        logic [7:0] t_red;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIX,
        ST_ADJ,
        ST_DET,
        ST_DCHK,
        ST_NUM,
        ST_DIV,
        ST_COEF,
        ST_EMIT
    } t_bk_state;

    // next index modulo three
    function automatic logic [1:0] nx3(input logic [1:0] a);
        logic [1:0] r;
        case (a)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // position of Gram entry (a, b) in the packed symmetric sums
    function automatic logic [2:0] gidx(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] r;
        case ({a, b})
            4'b0000: r = 3'd0;
            4'b0001: r = 3'd1;
            4'b0010: r = 3'd2;
            4'b0100: r = 3'd1;
            4'b0101: r = 3'd3;
            4'b0110: r = 3'd4;
            4'b1000: r = 3'd2;
            4'b1001: r = 3'd4;
            4'b1010: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // cross sum index of source channel j and target channel t
    function automatic logic [3:0] cidx(input logic [1:0] j, input logic [1:0] t);
        return 4'({2'b00, j} * 4'd3 + {2'b00, t});
    endfunction

endpackage
`default_nettype wire

### design/color_matrix_fit_and_apply_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_matrix_fit_and_apply_core: least-squares 3x3 colour matrix
// Fits a colour correction matrix from calibration pairs and applies it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata = blue, green, red, target blue, green, red (8 bits
//   each, low to high), tuser = op (0 pair, 1 pixel), tlast = last pair.
//   Master stream: tdata = corrected blue, green, red; tuser = is_fit_status,
//   fit_status. A plain pair gives no word; a last pair gives one status word.
//   Words pass through a four-entry queue into a sequencer that handles one
//   word at a time. A pixel is worked one output channel per cycle on three
//   16x8 multipliers, then registered for output. A pair is summed as it is
//   taken from the queue. A solve forms the adjugate on one 22x22 multiplier,
//   then runs a split 45x22 multiply-add and a 17-step restoring divider for
//   each of the nine coefficients.
//   Reset clears the sums and count and loads the identity matrix.
//   When the receiver stalls, the result word holds in the output register;
//   the queue keeps accepting until full, then tready drops.
// ----------------------------------------------------------------------------
module color_matrix_fit_and_apply_core
    import cmfa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // blue, green, red, target b, g, r
    input  wire logic [0:0]  i_s_axis_tuser,  // op
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // out_blue, out_green, out_red
    output logic [2:0]       o_m_axis_tuser   // is_fit_status, fit_status
);

    t_item   w_in_item, w_q_item;
    t_q_stat w_q_stat;
    logic    w_push, w_pop;

    cmfa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_stat        (w_q_stat),
        .o_push          (w_push),
        .o_item          (w_in_item)
    );

    cmfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    cmfa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_q_item),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

### design/cmfa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfa_front: input word intake
// Unpacks the slave stream word, classifies it and pushes it to the queue.
// ----------------------------------------------------------------------------
module cmfa_front
    import cmfa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,
    input  wire logic [0:0]  i_s_axis_tuser,
    input  wire logic        i_s_axis_tlast,
    input  wire t_q_stat     i_q_stat,
    output logic             o_push,
    output t_item            o_item
);

    logic w_unused;

    assign w_unused        = i_clk ^ i_rst_n;
    assign o_s_axis_tready = !i_q_stat.full;
    assign o_push          = i_s_axis_tvalid && !i_q_stat.full;

    // classify: pixel, plain pair, or pair that starts the solve
    always_comb begin
        o_item.blue    = i_s_axis_tdata[7:0];
        o_item.green   = i_s_axis_tdata[15:8];
        o_item.red     = i_s_axis_tdata[23:16];
        o_item.t_blue  = i_s_axis_tdata[31:24];
        o_item.t_green = i_s_axis_tdata[39:32];
        o_item.t_red   = i_s_axis_tdata[47:40];
        if (i_s_axis_tuser[0]) begin
            o_item.kind = K_PIXEL;
        end else if (i_s_axis_tlast) begin
            o_item.kind = K_SOLVE;
        end else begin
            o_item.kind = K_PAIR;
        end
    end

endmodule
`default_nettype wire

### design/cmfa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfa_queue: four-entry word queue
// Decouples the intake from the back end.
// ----------------------------------------------------------------------------
module cmfa_queue
    import cmfa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output t_q_stat    o_stat
);

    t_item      r_mem [4];
    logic [2:0] r_wp, r_rp;

    assign o_item       = r_mem[r_rp[1:0]];
    assign o_stat.empty = (r_wp == r_rp);
    assign o_stat.full  = (r_wp[1:0] == r_rp[1:0]) && (r_wp[2] != r_rp[2]);

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 3'd1;
            if (i_pop)  r_rp <= r_rp + 3'd1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp[1:0]] <= i_item;
    end

endmodule
`default_nettype wire

### design/cmfa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfa_back: accumulate, solve and apply
// Accumulates fit sums, solves the 3x3 matrix with a shared multiply-add and
// a restoring divider, applies the matrix to pixels, drives the result word.
// ----------------------------------------------------------------------------
module cmfa_back
    import cmfa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_item       i_item,
    input  wire t_q_stat     i_q_stat,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,
    output logic [2:0]       o_m_axis_tuser
);

    t_bk_state r_state, n_state;

    logic [SUM_W-1:0]         r_sps [6];
    logic [SUM_W-1:0]         r_cps [9];
    logic [CNT_W-1:0]         r_cnt;
    logic signed [COEF_W-1:0] r_mat [3][3];
    logic signed [ADJ_W-1:0]  r_adj [3][3];
    logic [SUM_W-1:0]         r_fa;
    logic [PROD_W-1:0]        r_prod;
    logic [1:0]               r_ph, r_i, r_j, r_r, r_k, r_ch;
    logic signed [ACC_W-1:0]  r_acc, r_det;
    logic [ACC_W-1:0]         r_dabs;
    logic [DIV_W-1:0]         r_rem, r_den;
    logic [Q_W-1:0]           r_q;
    logic [4:0]               r_dcnt;
    logic                     r_neg, r_ovf, r_sat, r_fit;
    logic [1:0]               r_status;
    t_item                    r_item;
    logic [7:0]               r_pix [3];
    logic                     r_ovalid;
    logic [23:0]              r_odata;
    logic [2:0]               r_ouser;

    logic                     w_emit;
    logic [2:0]               w_sidx;
    logic [SUM_W-1:0]         w_s, w_b;
    logic [PROD_W-1:0]        w_prod;
    logic signed [ADJ_W-1:0]  w_adj_new, w_a;
    logic [ADJ_W-1:0]         w_plo;
    logic signed [ADJ_W-1:0]  w_phi;
    logic signed [ACC_W-1:0]  w_acc_next;
    logic [ACC_W-1:0]         w_acc_abs;
    logic                     w_ge;
    logic [Q_W-1:0]           w_limit;
    logic                     w_csat;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [PIX_W-1:0]  w_pacc;
    logic [PIX_W-COEF_FRAC_BITS-1:0] w_psh;
    logic [7:0]               w_pch;
    logic                     w_room;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign w_emit          = (r_state == ST_EMIT) && (!r_ovalid || i_m_axis_tready);
    assign w_room          = (r_cnt < CNT_W'(MAX_PAIRS));

    // Gram sum read port: adjugate factors, then the determinant row
    always_comb begin
        case (r_ph)
            2'd0:    w_sidx = gidx(nx3(r_j), nx3(r_i));
            2'd1:    w_sidx = gidx(nx3(nx3(r_j)), nx3(nx3(r_i)));
            2'd2:    w_sidx = gidx(nx3(r_j), nx3(nx3(r_i)));
            default: w_sidx = gidx(nx3(nx3(r_j)), nx3(r_i));
        endcase
        if (r_state == ST_DET) w_sidx = {1'b0, r_i};
        w_s = r_sps[w_sidx];
    end

    assign w_prod    = PROD_W'(r_fa * w_s);
    assign w_adj_new = $signed({1'b0, r_prod}) - $signed({1'b0, w_prod});

    // shared multiply-add: signed adjugate times unsigned sum, in two halves
    always_comb begin
        if (r_state == ST_DET) begin
            w_a = r_adj[r_i][0];
            w_b = w_s;
        end else begin
            w_a = r_adj[r_j][r_k];
            w_b = r_cps[cidx(r_j, r_r)];
        end
        w_plo = ADJ_W'({{(ADJ_W-LO_W){1'b0}}, w_a[LO_W-1:0]} * {{(ADJ_W-SUM_W){1'b0}}, w_b});
        w_phi = $signed(w_a[ADJ_W-1:LO_W]) * $signed({1'b0, w_b});
        if (!r_ph[0]) begin
            w_acc_next = r_acc + $signed({{(ACC_W-ADJ_W){1'b0}}, w_plo});
        end else begin
            w_acc_next = r_acc + ($signed({{(ACC_W-ADJ_W){w_phi[ADJ_W-1]}}, w_phi}) <<< LO_W);
        end
        w_acc_abs = w_acc_next[ACC_W-1] ? ACC_W'(-w_acc_next) : ACC_W'(w_acc_next);
    end

    // divider step and coefficient rounding/saturation
    always_comb begin
        w_ge    = (r_rem >= r_den);
        w_limit = r_neg ? Q_W'(32768) : Q_W'(32767);
        w_csat  = r_ovf || (r_q > w_limit);
        if (w_csat) begin
            w_coef = r_neg ? COEF_W'(32768) : COEF_W'(32767);
        end else begin
            w_coef = r_neg ? COEF_W'(-r_q) : COEF_W'(r_q);
        end
    end

    // one output channel of a pixel
    always_comb begin
        w_pacc = PIX_W'(r_mat[r_ch][0] * $signed({1'b0, r_item.blue}))
               + PIX_W'(r_mat[r_ch][1] * $signed({1'b0, r_item.green}))
               + PIX_W'(r_mat[r_ch][2] * $signed({1'b0, r_item.red}));
        w_psh  = w_pacc[PIX_W-1:COEF_FRAC_BITS];
        if (w_pacc[PIX_W-1]) begin
            w_pch = 8'd0;
        end else if (w_psh > (PIX_W-COEF_FRAC_BITS)'(255)) begin
            w_pch = 8'd255;
        end else begin
            w_pch = w_psh[7:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    case (i_item.kind)
                        K_PIXEL: n_state = ST_PIX;
                        K_SOLVE: n_state = ST_ADJ;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIX:  if (r_ch == 2'd2) n_state = ST_EMIT;
            ST_ADJ:  if (r_ph == 2'd3 && r_i == 2'd2 && r_j == 2'd2) n_state = ST_DET;
            ST_DET:  if (r_ph[0] && r_i == 2'd2) n_state = ST_DCHK;
            ST_DCHK: n_state = (r_det == '0) ? ST_EMIT : ST_NUM;
            ST_NUM:  if (r_ph[0] && r_j == 2'd2) n_state = ST_DIV;
            ST_DIV:  if (r_dcnt == 5'(Q_W)) n_state = ST_COEF;
            ST_COEF: n_state = (r_r == 2'd2 && r_k == 2'd2) ? ST_EMIT : ST_NUM;
            ST_EMIT: if (w_emit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // sums, count, matrix and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_sps[i] <= '0;
            for (int i = 0; i < 9; i++) r_cps[i] <= '0;
            r_cnt <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mat[i][j] <= (i == j) ? COEF_W'(1 << COEF_FRAC_BITS) : '0;
                end
            end
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop && i_item.kind != K_PIXEL && w_room) begin
                r_sps[0] <= r_sps[0] + SUM_W'(i_item.blue  * i_item.blue);
                r_sps[1] <= r_sps[1] + SUM_W'(i_item.blue  * i_item.green);
                r_sps[2] <= r_sps[2] + SUM_W'(i_item.blue  * i_item.red);
                r_sps[3] <= r_sps[3] + SUM_W'(i_item.green * i_item.green);
                r_sps[4] <= r_sps[4] + SUM_W'(i_item.green * i_item.red);
                r_sps[5] <= r_sps[5] + SUM_W'(i_item.red   * i_item.red);
                r_cps[0] <= r_cps[0] + SUM_W'(i_item.blue  * i_item.t_blue);
                r_cps[1] <= r_cps[1] + SUM_W'(i_item.blue  * i_item.t_green);
                r_cps[2] <= r_cps[2] + SUM_W'(i_item.blue  * i_item.t_red);
                r_cps[3] <= r_cps[3] + SUM_W'(i_item.green * i_item.t_blue);
                r_cps[4] <= r_cps[4] + SUM_W'(i_item.green * i_item.t_green);
                r_cps[5] <= r_cps[5] + SUM_W'(i_item.green * i_item.t_red);
                r_cps[6] <= r_cps[6] + SUM_W'(i_item.red   * i_item.t_blue);
                r_cps[7] <= r_cps[7] + SUM_W'(i_item.red   * i_item.t_green);
                r_cps[8] <= r_cps[8] + SUM_W'(i_item.red   * i_item.t_red);
                r_cnt    <= r_cnt + CNT_W'(1);
            end
            // a finished solve starts a fresh fit
            if (r_state == ST_EMIT && r_fit) begin
                for (int i = 0; i < 6; i++) r_sps[i] <= '0;
                for (int i = 0; i < 9; i++) r_cps[i] <= '0;
                r_cnt <= '0;
            end
            if (r_state == ST_COEF) r_mat[r_r][r_k] <= w_coef;
            if (w_emit)               r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    // solver and pixel datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_item;
                r_ch   <= '0;
                r_ph   <= '0;
                r_i    <= '0;
                r_j    <= '0;
                r_sat  <= 1'b0;
                r_fit  <= (i_item.kind != K_PIXEL);
            end
            ST_PIX: begin
                r_pix[r_ch] <= w_pch;
                r_ch        <= r_ch + 2'd1;
            end
            ST_ADJ: begin
                r_ph <= r_ph + 2'd1;
                case (r_ph)
                    2'd1:    r_prod <= w_prod;
                    2'd3:    r_adj[r_i][r_j] <= w_adj_new;
                    default: r_fa <= w_s;
                endcase
                if (r_ph == 2'd3) begin
                    if (r_j == 2'd2) begin
                        r_j <= '0;
                        r_i <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                r_acc <= '0;
            end
            ST_DET: begin
                r_acc <= w_acc_next;
                r_ph  <= {1'b0, ~r_ph[0]};
                if (r_ph[0]) r_i <= r_i + 2'd1;
                r_det <= w_acc_next;
            end
            ST_DCHK: begin
                r_dabs   <= r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);
                r_r      <= '0;
                r_k      <= '0;
                r_j      <= '0;
                r_ph     <= '0;
                r_acc    <= '0;
                r_status <= FIT_SINGULAR;
            end
            ST_NUM: begin
                r_acc <= w_acc_next;
                r_ph  <= {1'b0, ~r_ph[0]};
                if (r_ph[0]) r_j <= r_j + 2'd1;
                r_neg  <= w_acc_next[ACC_W-1] ^ r_det[ACC_W-1];
                r_rem  <= ({{(DIV_W-ACC_W){1'b0}}, w_acc_abs} << (COEF_FRAC_BITS + 1))
                        + {{(DIV_W-ACC_W){1'b0}}, r_dabs};
                r_den  <= {{(DIV_W-ACC_W){1'b0}}, r_dabs} << (Q_W + 1);
                r_dcnt <= '0;
                r_q    <= '0;
            end
            ST_DIV: begin
                r_den  <= r_den >> 1;
                r_dcnt <= r_dcnt + 5'd1;
                if (r_dcnt == '0) begin
                    r_ovf <= w_ge;
                end else if (w_ge) begin
                    r_rem <= r_rem - r_den;
                    r_q   <= {r_q[Q_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[Q_W-2:0], 1'b0};
                end
            end
            ST_COEF: begin
                r_sat    <= r_sat | w_csat;
                r_status <= (r_sat | w_csat) ? FIT_SAT : FIT_OK;
                r_acc    <= '0;
                r_j      <= '0;
                r_ph     <= '0;
                if (r_k == 2'd2) begin
                    r_k <= '0;
                    r_r <= r_r + 2'd1;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    if (r_fit) begin
                        r_odata <= '0;
                        r_ouser <= {r_status, 1'b1};
                    end else begin
                        r_odata <= {r_pix[2], r_pix[1], r_pix[0]};
                        r_ouser <= {FIT_OK, 1'b0};
                    end
                end
            end
            default: begin
                r_ph <= '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/cmfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfa_checker: port checks for the colour matrix core
// Watches the result stream for format and hold rules.
// ----------------------------------------------------------------------------
`include "color_matrix_fit_and_apply_core_assert.svh"

module cmfa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic [2:0]  o_m_axis_tuser
);

    // a stalled result word holds
    `CMFA_ASSERT_RST(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result word changed under stall")
    // status words carry no colour
    `CMFA_ASSERT_RST(a_fit_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 24'd0, "status word with colour data")
    // pixel words carry status ok; status words never carry status code three
    `CMFA_ASSERT_RST(a_pix_stat, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tuser[0] ? o_m_axis_tuser[2:1] != 2'd3 : o_m_axis_tuser[2:1] == 2'd0), "bad fit status")
    // nothing leaves right after reset
    `CMFA_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind color_matrix_fit_and_apply_core cmfa_checker u_cmfa_checker (.*);
`default_nettype wire
